/* rtl/core/sfp_pkg.sv */
package sfp_pkg;

  // Fixed field widths of the byte stream and result items
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 6;
  localparam int IDX_W    = 6;

  // Bytes of each frame that are not payload: two sync, class, id, length, checksum
  localparam int FRAME_OVERHEAD = 6;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN     = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CHECK   = 4'd6,
    PH_EMIT_RD = 4'd7,
    PH_EMIT_LD = 4'd8
  } phase_t;

endpackage

/* rtl/core/sfp_ram.sv */
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 58
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/sync_frame_parser_top.sv */
// After its checksum byte is taken, an empty frame's marker goes straight to the output load;
//   otherwise each payload byte is read from the RAM, then loaded into the output register.
// Header and payload bytes are taken at 1 per cycle while no frame is being emitted; input is
//   held during emission (RAM read, then output load), plus any out_ready stalls.
// Reset (rst_n, synchronous, active low): parser back to first-sync hunt, output empty,
//   sync registers to 181 / 98. Payload RAM is not cleared.
module sync_frame_parser_top #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,

  // Byte request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfp_pkg::BYTE_W-1:0]    in_rx_byte,

  // Result request channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfp_pkg::BYTE_W-1:0]    out_msg_class,
  output logic [sfp_pkg::BYTE_W-1:0]    out_msg_id,
  output logic [sfp_pkg::LEN_W-1:0]     out_payload_length,
  output logic                          out_has_data,
  output logic [sfp_pkg::IDX_W-1:0]     out_byte_index,
  output logic [sfp_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [sfp_pkg::BYTE_W-1:0]    out_frame_checksum,
  output logic                          out_last,

  // Configuration write port
  input  logic                          cfg_wr_en,
  input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfp_pkg::BYTE_W-1:0]    cfg_wr_data
);

  // Largest payload a frame may carry; longer length bytes drop the frame.
  localparam int PL = MAX_FRAME_BYTES - sfp_pkg::FRAME_OVERHEAD;
  // Length / index width (holds 0..PL) and RAM address width
  localparam int LW = $clog2(PL + 1);
  localparam int AW = (PL > 1) ? $clog2(PL) : 1;
  localparam logic [sfp_pkg::BYTE_W:0] LIMIT9 = PL[sfp_pkg::BYTE_W:0];
  localparam logic [LW:0] ONE_L = (LW+1)'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sfp_pkg::BYTE_W-1:0] sync_first_r;
  logic [sfp_pkg::BYTE_W-1:0] sync_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= sfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= sfp_pkg::SYNC_SECOND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wr_data;
        sfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  sfp_pkg::phase_t phase_r, phase_nxt;

  logic [sfp_pkg::BYTE_W-1:0] class_r,  class_nxt;
  logic [sfp_pkg::BYTE_W-1:0] id_r,     id_nxt;
  logic [LW-1:0]              len_r,    len_nxt;
  logic [LW-1:0]              fill_r,   fill_nxt;
  logic [sfp_pkg::BYTE_W-1:0] sum_r,    sum_nxt;
  logic [sfp_pkg::BYTE_W-1:0] chk_r,    chk_nxt;
  logic [LW-1:0]              rd_idx_r, rd_idx_nxt;

  // Output register: one result held until taken
  logic                       out_valid_r, out_valid_nxt;
  logic [sfp_pkg::LEN_W-1:0]  o_len_r,   o_len_nxt;
  logic [sfp_pkg::BYTE_W-1:0] o_class_r, o_class_nxt;
  logic [sfp_pkg::BYTE_W-1:0] o_id_r,    o_id_nxt;
  logic                       o_has_r,   o_has_nxt;
  logic [sfp_pkg::IDX_W-1:0]  o_idx_r,   o_idx_nxt;
  logic [sfp_pkg::BYTE_W-1:0] o_data_r,  o_data_nxt;
  logic [sfp_pkg::BYTE_W-1:0] o_chk_r,   o_chk_nxt;
  logic                       o_last_r,  o_last_nxt;

  // Payload RAM interface
  logic                       ram_we;
  logic                       ram_re;
  logic [sfp_pkg::BYTE_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic emit_last;
  logic emit_load;

  sfp_ram #(
    .WIDTH (sfp_pkg::BYTE_W),
    .DEPTH (PL)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Input is blocked only in the emit phases, while a frame is put out; writes
  // happen in the payload phase and reads in the emit phases, so the two
  // never touch the RAM in the same cycle.
  assign in_ready  = (phase_r != sfp_pkg::PH_EMIT_RD) && (phase_r != sfp_pkg::PH_EMIT_LD);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  // Final result: last payload index, or the lone marker of an empty frame
  assign emit_last = (len_r == '0) || (({1'b0, rd_idx_r} + ONE_L) == {1'b0, len_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfp_pkg::PH_SYNC1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    class_r   <= class_nxt;
    id_r      <= id_nxt;
    len_r     <= len_nxt;
    fill_r    <= fill_nxt;
    sum_r     <= sum_nxt;
    chk_r     <= chk_nxt;
    rd_idx_r  <= rd_idx_nxt;
    o_class_r <= o_class_nxt;
    o_id_r    <= o_id_nxt;
    o_len_r   <= o_len_nxt;
    o_has_r   <= o_has_nxt;
    o_idx_r   <= o_idx_nxt;
    o_data_r  <= o_data_nxt;
    o_chk_r   <= o_chk_nxt;
    o_last_r  <= o_last_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    class_nxt     = class_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    chk_nxt       = chk_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_class_nxt   = o_class_r;
    o_id_nxt      = o_id_r;
    o_len_nxt     = o_len_r;
    o_has_nxt     = o_has_r;
    o_idx_nxt     = o_idx_r;
    o_data_nxt    = o_data_r;
    o_chk_nxt     = o_chk_r;
    o_last_nxt    = o_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    emit_load     = 1'b0;

    unique case (phase_r)
      sfp_pkg::PH_SYNC1: begin
        if (in_fire && (in_rx_byte == sync_first_r)) begin
          phase_nxt = sfp_pkg::PH_SYNC2;
        end
      end
      sfp_pkg::PH_SYNC2: begin
        // A wrong second byte is dropped, not rechecked as a first sync
        if (in_fire) begin
          phase_nxt = (in_rx_byte == sync_second_r) ? sfp_pkg::PH_CLASS : sfp_pkg::PH_SYNC1;
        end
      end
      sfp_pkg::PH_CLASS: begin
        if (in_fire) begin
          class_nxt = in_rx_byte;
          sum_nxt   = in_rx_byte;
          phase_nxt = sfp_pkg::PH_ID;
        end
      end
      sfp_pkg::PH_ID: begin
        if (in_fire) begin
          id_nxt    = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          phase_nxt = sfp_pkg::PH_LEN;
        end
      end
      sfp_pkg::PH_LEN: begin
        if (in_fire) begin
          if ({1'b0, in_rx_byte} > LIMIT9) begin
            phase_nxt = sfp_pkg::PH_SYNC1;
          end else begin
            len_nxt   = in_rx_byte[LW-1:0];
            sum_nxt   = sum_r + in_rx_byte;
            fill_nxt  = '0;
            phase_nxt = (in_rx_byte == '0) ? sfp_pkg::PH_CHECK : sfp_pkg::PH_PAYLOAD;
          end
        end
      end
      sfp_pkg::PH_PAYLOAD: begin
        if (in_fire) begin
          ram_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
          sum_nxt  = sum_r + in_rx_byte;
          if (({1'b0, fill_r} + ONE_L) >= {1'b0, len_r}) begin
            phase_nxt = sfp_pkg::PH_CHECK;
          end
        end
      end
      sfp_pkg::PH_CHECK: begin
        if (in_fire) begin
          chk_nxt    = in_rx_byte;
          rd_idx_nxt = '0;
          if (in_rx_byte == sum_r) begin
            // Empty frame needs no RAM read
            phase_nxt = (len_r == '0) ? sfp_pkg::PH_EMIT_LD : sfp_pkg::PH_EMIT_RD;
          end else begin
            phase_nxt = sfp_pkg::PH_SYNC1;
          end
        end
      end
      sfp_pkg::PH_EMIT_RD: begin
        ram_re    = 1'b1;
        phase_nxt = sfp_pkg::PH_EMIT_LD;
      end
      sfp_pkg::PH_EMIT_LD: begin
        // RAM data holds until the next read, so wait here for room
        if (out_free) begin
          emit_load     = 1'b1;
          out_valid_nxt = 1'b1;
          o_class_nxt   = class_r;
          o_id_nxt      = id_r;
          o_len_nxt     = sfp_pkg::LEN_W'(len_r);
          o_has_nxt     = (len_r != '0);
          o_idx_nxt     = sfp_pkg::IDX_W'(rd_idx_r);
          o_data_nxt    = (len_r != '0) ? ram_rdata : '0;
          o_chk_nxt     = chk_r;
          o_last_nxt    = emit_last;
          if (emit_last) begin
            phase_nxt = sfp_pkg::PH_SYNC1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
            phase_nxt  = sfp_pkg::PH_EMIT_RD;
          end
        end
      end
      default: begin
        // Unused phase code: consume the byte and resume hunting
        if (in_fire) begin
          phase_nxt = sfp_pkg::PH_SYNC1;
        end
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_msg_class      = o_class_r;
  assign out_msg_id         = o_id_r;
  assign out_payload_length = o_len_r;
  assign out_has_data       = o_has_r;
  assign out_byte_index     = o_idx_r;
  assign out_data_byte      = o_data_r;
  assign out_frame_checksum = o_chk_r;
  assign out_last           = o_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfp_pkg::PH_PAYLOAD) |-> ({1'b0, fill_r} < {1'b0, len_r}))
    else $error("payload fill index beyond frame length");

  a_len_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfp_pkg::PH_PAYLOAD || phase_r == sfp_pkg::PH_CHECK ||
     phase_r == sfp_pkg::PH_EMIT_RD || phase_r == sfp_pkg::PH_EMIT_LD)
    |-> ({1'b0, len_r} <= LIMIT9))
    else $error("held length above payload limit");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfp_pkg::PH_EMIT_RD || phase_r == sfp_pkg::PH_EMIT_LD)
    |-> (len_r == '0 || rd_idx_r < len_r))
    else $error("emit read index beyond frame length");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && emit_last) |=> (phase_r == sfp_pkg::PH_SYNC1 && out_valid_r && out_last))
    else $error("final result did not end the frame run");

  a_no_emit_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

endmodule
